/* hdl/b64sc_pkg.sv */
// shared types, constants and character mapping functions for the base64 stream codec
package b64sc_pkg;

  localparam logic [7:0] PAD_CHAR     = 8'd61;
  localparam int         MAX_RESULTS  = 4;
  localparam int         CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam logic       DIR_ENCODE   = 1'b0;
  localparam logic       DIR_DECODE   = 1'b1;
  localparam logic       DIRECTION_RST = DIR_ENCODE;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  // results of one finished group, slot 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]            count;
    res_t [MAX_RESULTS-1:0]      slot;
  } grp_t;

  // sextet to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    begin
      if (v < 6'd26) begin
        c = 8'd65 + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'd71 + {2'b00, v};
      end else if (v < 6'd62) begin
        c = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
        c = 8'd43;
      end else begin
        c = 8'd47;
      end
      return c;
    end
  endfunction

  // character to sextet, anything outside the alphabet gives zero
  function automatic logic [5:0] b64_sextet(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= 8'd65 && c <= 8'd90) begin
        t = c - 8'd65;
      end else if (c >= 8'd97 && c <= 8'd122) begin
        t = c - 8'd71;
      end else if (c >= 8'd48 && c <= 8'd57) begin
        t = c + 8'd4;
      end else if (c == 8'd43) begin
        t = 8'd62;
      end else if (c == 8'd47) begin
        t = 8'd63;
      end
      return t[5:0];
    end
  endfunction

endpackage

/* hdl/base64_stream_codec.sv */
// top level of the base64 stream codec
//
// in_* takes one word per handshake: a message byte when encoding or a
// base64 character when decoding, with in_tlast on the final word of a
// message. out_* gives characters (encode) or bytes (decode); out_tuser
// clear with out_tlast set is an empty end marker for a message whose
// last word produced no byte. cfg_we/cfg_wdata write the direction
// (0 encode, 1 decode) and clear any partly gathered group.
// A word is held in the input register; a group with results that it
// finishes is loaded into the result buffer once it is free, and its
// first result is on out_* the next cycle. The buffer drains one word
// per cycle unless out_tready stalls: encode gives four characters per
// three bytes, so its input waits on the buffer; decode takes one word
// per cycle. Words that only add to a group are taken while the buffer
// drains. Reset clears the direction to encode, the group and the buffer.
// A stall on out_tready holds the buffer; once the input register holds
// a word that finishes a group, in_tready stays low until the buffer frees.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,     // direction
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tuser,     // [0] data_valid
  output logic       out_tlast
);
  import b64sc_pkg::*;

  logic grp_valid;
  logic grp_ready;
  grp_t grp;

  b64sc_group u_group (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  b64sc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready),
    .grp        (grp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* hdl/b64sc_group.sv */
// input register and group assembly, turns one word into a finished group of results
module b64sc_group (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  output logic                grp_valid,
  input  logic                grp_ready,
  output b64sc_pkg::grp_t     grp
);
  import b64sc_pkg::*;

  logic        direction_r;
  logic        hold_valid_r;
  logic [7:0]  hold_byte_r;
  logic        hold_last_r;
  logic [23:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_fill_r, group_fill_nxt;
  logic [1:0]  pad_count_r,  pad_count_nxt;

  logic [23:0] bits_upd;
  logic [1:0]  pad_upd;
  logic [2:0]  n;
  logic [2:0]  nb_raw;
  logic [2:0]  nb;
  logic [5:0]  sx;
  logic        complete;
  logic        need;
  logic        fire;
  grp_t        grp_c;

  always_comb begin
    n        = {1'b0, group_fill_r} + 3'd1;
    bits_upd = group_bits_r;
    pad_upd  = pad_count_r;
    sx       = b64_sextet(hold_byte_r);
    nb_raw   = 3'd0;
    nb       = 3'd0;
    complete = 1'b0;
    grp_c    = '0;
    if (direction_r == DIR_ENCODE) begin
      case (group_fill_r)
        2'd0:    bits_upd = group_bits_r | {hold_byte_r, 16'd0};
        2'd1:    bits_upd = group_bits_r | {8'd0, hold_byte_r, 8'd0};
        2'd2:    bits_upd = group_bits_r | {16'd0, hold_byte_r};
        default: bits_upd = group_bits_r;
      endcase
      complete    = (n == 3'd3) || hold_last_r;
      grp_c.count = CNT_W'(4);
      for (int k = 0; k < 4; k++) begin
        // characters past the data become padding
        if (3'(k) < n + 3'd1) begin
          grp_c.slot[k].data = b64_char(bits_upd[23 - 6*k -: 6]);
        end else begin
          grp_c.slot[k].data = PAD_CHAR;
        end
        grp_c.slot[k].valid = 1'b1;
        grp_c.slot[k].last  = hold_last_r && (k == 3);
      end
    end else begin
      if (hold_byte_r == PAD_CHAR) begin
        if (pad_count_r != 2'd3) begin
          pad_upd = pad_count_r + 2'd1;
        end
      end else begin
        case (group_fill_r)
          2'd0:    bits_upd = group_bits_r | {sx, 18'd0};
          2'd1:    bits_upd = group_bits_r | {6'd0, sx, 12'd0};
          2'd2:    bits_upd = group_bits_r | {12'd0, sx, 6'd0};
          2'd3:    bits_upd = group_bits_r | {18'd0, sx};
          default: bits_upd = group_bits_r;
        endcase
      end
      complete = (n == 3'd4) || hold_last_r;
      nb_raw   = (n == 3'd4) ? 3'd3 : n - 3'd1;
      nb       = (nb_raw > {1'b0, pad_upd}) ? nb_raw - {1'b0, pad_upd} : 3'd0;
      for (int k = 0; k < 3; k++) begin
        grp_c.slot[k].data  = bits_upd[23 - 8*k -: 8];
        grp_c.slot[k].valid = 1'b1;
        grp_c.slot[k].last  = hold_last_r && (3'(k + 1) == nb);
      end
      grp_c.count = CNT_W'(nb);
      // empty end marker
      if (nb == 3'd0 && hold_last_r) begin
        grp_c.slot[0] = '{data: 8'd0, valid: 1'b0, last: 1'b1};
        grp_c.count   = CNT_W'(1);
      end
    end
  end

  assign need      = complete && (grp_c.count != '0);
  assign fire      = hold_valid_r && (!need || grp_ready);
  assign grp_valid = hold_valid_r && need;
  assign grp       = grp_c;
  assign in_tready = !hold_valid_r || fire;

  always_comb begin
    group_bits_nxt = group_bits_r;
    group_fill_nxt = group_fill_r;
    pad_count_nxt  = pad_count_r;
    if (cfg_we) begin
      group_bits_nxt = '0;
      group_fill_nxt = '0;
      pad_count_nxt  = '0;
    end else if (fire) begin
      if (complete) begin
        group_bits_nxt = '0;
        group_fill_nxt = '0;
        pad_count_nxt  = '0;
      end else begin
        group_bits_nxt = bits_upd;
        group_fill_nxt = n[1:0];
        pad_count_nxt  = pad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= DIRECTION_RST;
      hold_valid_r <= 1'b0;
      group_bits_r <= '0;
      group_fill_r <= '0;
      pad_count_r  <= '0;
    end else begin
      if (cfg_we) begin
        direction_r <= cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        hold_valid_r <= 1'b1;
      end else if (fire) begin
        hold_valid_r <= 1'b0;
      end
      group_bits_r <= group_bits_nxt;
      group_fill_r <= group_fill_nxt;
      pad_count_r  <= pad_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_byte_r <= in_tdata;
      hold_last_r <= in_tlast;
    end
  end

endmodule

/* hdl/b64sc_emit.sv */
// result buffer that drains a finished group one word per cycle unless stalled
module b64sc_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             grp_valid,
  output logic             grp_ready,
  input  b64sc_pkg::grp_t  grp,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import b64sc_pkg::*;

  res_t [MAX_RESULTS-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pop;
  logic                   load;

  assign pop       = out_tvalid && out_tready;
  // free now, or the last buffered word leaves this cycle
  assign grp_ready = (cnt_r == '0) || (cnt_r == CNT_W'(1) && pop);
  assign load      = grp_valid && grp_ready;

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = grp.slot;
      cnt_nxt  = grp.count;
    end else if (pop) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) begin
        slot_nxt[k] = slot_r[k + 1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = slot_r[0].data;
  assign out_tuser  = slot_r[0].valid;
  assign out_tlast  = slot_r[0].last;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == '0 || (cnt_r == CNT_W'(1) && pop)))
    else $error("group loaded over pending results");

  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && slot_r[0].last) |-> cnt_r == CNT_W'(1))
    else $error("last word is not the final buffered word");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !slot_r[0].valid) |-> slot_r[0].last)
    else $error("empty marker without last");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("buffer count did not drop after a pop");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the base64 stream codec: directed and random messages
module testbench;
  import b64sc_pkg::*;

  localparam int STALL_LIMIT = 600;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       dv;
    logic       last;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  // codec state as predicted
  logic        cur_dir = DIR_ENCODE;
  logic [23:0] grp_bits = 24'd0;
  int unsigned grp_fill = 0;
  int unsigned grp_pads = 0;
  out_word_t   exp_q[$];

  logic [7:0]  run_q[$];
  bit          idle_en = 1'b0;
  int          err_cnt = 0;
  int          idle_cycles = 0;

  base64_stream_codec i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] alpha_char(input int unsigned v);
    return ALPHABET[8*(63-v) +: 8];
  endfunction

  // reverse lookup in the alphabet, anything else counts as zero
  function automatic int unsigned sextet_val(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alpha_char(i) == c) return i;
    end
    return 0;
  endfunction

  function automatic void push_exp(input logic [7:0] d, input logic v, input logic l);
    out_word_t w;
    w.data = d;
    w.dv   = v;
    w.last = l;
    exp_q.push_back(w);
  endfunction

  function automatic void clear_group();
    grp_bits = 24'd0;
    grp_fill = 0;
    grp_pads = 0;
  endfunction

  task automatic predict_word(input logic [7:0] b, input logic l);
    int unsigned n;
    int unsigned nb;
    n = grp_fill + 1;
    if (cur_dir == DIR_ENCODE) begin
      grp_bits = grp_bits | ({16'd0, b} << (16 - 8*grp_fill));
      if (n < 3 && !l) begin
        grp_fill = n;
      end else begin
        // n bytes give n+1 characters, the rest of the four are padding
        for (int k = 0; k < 4; k++) begin
          push_exp((k < n + 1) ? alpha_char((grp_bits >> (18 - 6*k)) & 24'd63) : PAD_CHAR,
                   1'b1, l && k == 3);
        end
        clear_group();
      end
    end else begin
      if (b == PAD_CHAR) begin
        if (grp_pads < 3) grp_pads++;
      end else begin
        grp_bits = grp_bits | ({18'd0, 6'(sextet_val(b))} << (18 - 6*grp_fill));
      end
      if (n < 4 && !l) begin
        grp_fill = n;
      end else begin
        nb = (n == 4) ? 3 : n - 1;
        nb = (nb > grp_pads) ? nb - grp_pads : 0;
        for (int k = 0; k < nb; k++) begin
          push_exp(grp_bits[23-8*k -: 8], 1'b1, l && (k + 1 == nb));
        end
        if (nb == 0 && l) push_exp(8'd0, 1'b0, 1'b1);
        clear_group();
      end
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic l);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(b, l);
  endtask

  task automatic send_run(input logic l);
    for (int i = 0; i < run_q.size(); i++) begin
      send_word(run_q[i], l && (i == run_q.size() - 1));
    end
  endtask

  task automatic send_chars(input string s, input logic l);
    run_q.delete();
    for (int i = 0; i < s.len(); i++) run_q.push_back(s[i]);
    send_run(l);
  endtask

  task automatic fill_bytes(input int n);
    run_q.delete();
    repeat (n) run_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // turn the bytes in run_q into base64 text, with or without the pad characters
  task automatic to_text(input bit keep_pad);
    logic [7:0]  src[$];
    logic [23:0] g;
    int          m;
    src = run_q;
    run_q.delete();
    for (int i = 0; i < src.size(); i += 3) begin
      m = src.size() - i;
      if (m > 3) m = 3;
      g = {src[i], (m > 1) ? src[i+1] : 8'd0, (m > 2) ? src[i+2] : 8'd0};
      for (int k = 0; k < 4; k++) begin
        if (k <= m) begin
          run_q.push_back(alpha_char(g[23-6*k -: 6]));
        end else if (keep_pad) begin
          run_q.push_back(PAD_CHAR);
        end
      end
    end
  endtask

  // only while idle: wait for the last word out and for any word still inside
  task automatic set_direction(input logic d);
    in_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_dir = d;
    clear_group();
  endtask

  task automatic run_encode(input int n);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n) begin
      len = $urandom_range(1, 8);
      fill_bytes(len);
      // now and then a message is sent without last, leaving any partial group open
      send_run($urandom_range(0, 7) != 0);
      cnt += len;
    end
  endtask

  task automatic run_decode(input int n);
    int cnt;
    int pick;
    int len;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        fill_bytes($urandom_range(1, 6));
        to_text(pick < 5);
        send_run(1'b1);
      end else begin
        len = $urandom_range(1, 6);
        run_q.delete();
        repeat (len) begin
          case ($urandom_range(0, 2))
            0: begin
              run_q.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
              run_q.push_back(PAD_CHAR);
            end
            default: begin
              run_q.push_back(alpha_char($urandom_range(0, 63)));
            end
          endcase
        end
        send_run(1'($urandom_range(0, 1)));
      end
      cnt += run_q.size();
    end
  endtask

  task automatic test_encode_directed();
    idle_en = 1'b1;
    set_direction(DIR_ENCODE);
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b1);
    send_word(8'h4d, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h6e, 1'b0);
    send_word(8'h80, 1'b1);
  endtask

  task automatic test_decode_directed();
    set_direction(DIR_DECODE);
    send_chars("Az+/", 1'b0);
    send_chars("Za09", 1'b1);
    // characters just outside the alphabet ranges, then a pad
    send_chars("{@`=", 1'b1);
    // leading pad, nothing left but the end marker
    send_chars("=[==", 1'b1);
    send_chars("A", 1'b1);
  endtask

  task automatic test_rewrite_mid_group();
    set_direction(DIR_ENCODE);
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b0);
    set_direction(DIR_ENCODE);
    send_word(8'h56, 1'b1);
    set_direction(DIR_DECODE);
    send_chars("T=", 1'b0);
    set_direction(DIR_DECODE);
    send_chars("TQ", 1'b1);
  endtask

  task automatic test_encode_random();
    idle_en = 1'b1;
    set_direction(DIR_ENCODE);
    run_encode(30);
  endtask

  task automatic test_decode_random();
    idle_en = 1'b1;
    set_direction(DIR_DECODE);
    run_decode(45);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    set_direction(DIR_ENCODE);
    run_encode(12);
    set_direction(DIR_DECODE);
    run_decode(12);
  endtask

  // receiver stalls in bursts while idling is on
  initial begin
    forever begin
      out_tready <= 1'b1;
      @(posedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_q.size() == 0) begin
        $error("result word with none expected: out_byte %0h", out_tdata);
        err_cnt++;
      end else begin
        want = exp_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %0h, actual %0h", want.data, out_tdata);
          err_cnt++;
        end
        if (out_tuser !== want.dv) begin
          $error("data_valid: expected %0b, actual %0b", want.dv, out_tuser);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last: expected %0b, actual %0b", want.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_directed();
    test_decode_directed();
    test_rewrite_mid_group();
    test_encode_random();
    test_decode_random();
    test_back_to_back();
    in_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
